### hw/rtl/mhpl_pkg.sv
package mhpl_pkg;

    // Store geometry
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 512;
    localparam int MARKER_COUNT = 4;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);

    // Word field widths
    localparam int PIX_W   = 8;
    localparam int POWER_W = 24;
    localparam int CX_W    = 14;
    localparam int CY_W    = 13;
    localparam int MARK_W  = 3;

    // Configuration register widths and codes
    localparam int FW_W       = 11;
    localparam int FH_W       = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POWER_THRESHOLD = 2'd2;

    localparam logic [FW_W-1:0]    FRAME_WIDTH_RST     = 11'd640;
    localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST    = 10'd480;
    localparam logic [POWER_W-1:0] POWER_THRESHOLD_RST = 24'd1000;

    // Action codes
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Peak tracking sums and count
    localparam int SUMX_W = COL_W + ADDR_W;
    localparam int SUMY_W = ROW_W + ADDR_W;
    localparam int CNT_W  = ADDR_W + 1;

    // Centroid divider: sums scaled by 16 (4 fraction bits)
    localparam int FRAC_W  = 4;
    localparam int DIV_W   = SUMX_W + FRAC_W;
    localparam int STEP_W  = $clog2(DIV_W + 1);

    localparam logic [POWER_W-1:0] POWER_SAT = {POWER_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

### hw/rtl/mhpl_store.sv
module mhpl_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [mhpl_pkg::ADDR_W-1:0] i_waddr,
    input  logic [mhpl_pkg::POWER_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [mhpl_pkg::ADDR_W-1:0] i_raddr,
    output logic [mhpl_pkg::POWER_W-1:0] o_rdata
);
    import mhpl_pkg::*;

    logic [POWER_W-1:0] r_mem [STORE_DEPTH];
    logic [POWER_W-1:0] r_rdata;

    // Read old data on a same-address collision, write new data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/mhpl_centroid_div.sv
module mhpl_centroid_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mhpl_pkg::SUMX_W-1:0] i_sum_x,
    input  logic [mhpl_pkg::SUMY_W-1:0] i_sum_y,
    input  logic [mhpl_pkg::CNT_W-1:0]  i_count,
    input  logic                        i_take,
    output mhpl_pkg::t_div_ctl          o_ctl,
    output logic [mhpl_pkg::CX_W-1:0]   o_quot_x,
    output logic [mhpl_pkg::CY_W-1:0]   o_quot_y
);
    import mhpl_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_den;
    logic [DIV_W-1:0]  r_num_x;
    logic [DIV_W-1:0]  r_num_y;
    logic [CNT_W-1:0]  r_rem_x;
    logic [CNT_W-1:0]  r_rem_y;

    logic [CNT_W:0]    trial_x;
    logic [CNT_W:0]    trial_y;
    logic              q_x;
    logic              q_y;
    logic [CNT_W-1:0]  n_rem_x;
    logic [CNT_W-1:0]  n_rem_y;

    // One restoring step per cycle on both lanes
    always_comb begin
        trial_x = {r_rem_x, r_num_x[DIV_W-1]};
        trial_y = {r_rem_y, r_num_y[DIV_W-1]};
        q_x     = (trial_x >= {1'b0, r_den});
        q_y     = (trial_y >= {1'b0, r_den});
        n_rem_x = q_x ? CNT_W'(trial_x - {1'b0, r_den}) : trial_x[CNT_W-1:0];
        n_rem_y = q_y ? CNT_W'(trial_y - {1'b0, r_den}) : trial_y[CNT_W-1:0];
    end

    // Control: load, iterate, hold the quotient until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (r_done && i_take) begin
            r_done <= 1'b0;
        end
    end

    // Datapath: quotient bits shift into the dividend registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den   <= i_count;
            r_num_x <= DIV_W'({i_sum_x, {FRAC_W{1'b0}}});
            r_num_y <= DIV_W'({i_sum_y, {FRAC_W{1'b0}}});
            r_rem_x <= '0;
            r_rem_y <= '0;
        end else if (r_busy) begin
            r_num_x <= {r_num_x[DIV_W-2:0], q_x};
            r_num_y <= {r_num_y[DIV_W-2:0], q_y};
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
        end
    end

    assign o_ctl.busy = r_busy;
    assign o_ctl.done = r_done;
    assign o_quot_x   = r_num_x[CX_W-1:0];
    assign o_quot_y   = r_num_y[CY_W-1:0];

endmodule

### hw/rtl/motion_hot_point_locator.sv
// Motion hot point locator.
// Input channel (i_in_valid / o_in_stall) takes one word per pixel pair in
// raster order, or a clear action. Output channel (o_out_valid / i_out_stall)
// gives one word at the last pixel of each frame: peak power, centroid of
// the peak pixels (4 fraction bits), marker flags and count.
// Within a frame one pixel is taken per cycle: the store read happens in the
// accept cycle, the saturating add and write-back in the next, with a
// forward path for back-to-back hits on one address.
// After the last pixel of a frame the input stalls while the two-lane
// centroid divider runs its 33 steps; the result word is loaded when the
// output register is free. The output register holds a word
// under stall while new pixels are taken; a later frame end waits for it.
// A found marker or a clear action sweeps all 524288 store entries, one per
// cycle, with the input stalled; the same sweep runs after reset.
// Once four markers are found, pixel words are taken and dropped until a
// clear action. Configuration writes are taken in any cycle.
module motion_hot_point_locator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [mhpl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mhpl_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_action,
    input  logic [mhpl_pkg::PIX_W-1:0]       i_current_pixel,
    input  logic [mhpl_pkg::PIX_W-1:0]       i_previous_pixel,
    // Output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [mhpl_pkg::POWER_W-1:0]     o_peak_power,
    output logic [mhpl_pkg::CX_W-1:0]        o_centroid_x,
    output logic [mhpl_pkg::CY_W-1:0]        o_centroid_y,
    output logic                             o_marker_found,
    output logic [mhpl_pkg::MARK_W-1:0]      o_marker_number,
    output logic                             o_all_found
);
    import mhpl_pkg::*;

    localparam logic [FW_W-1:0]     W_MAX    = FW_W'(MAX_WIDTH);
    localparam logic [FH_W-1:0]     H_MAX    = FH_W'(MAX_HEIGHT);
    localparam logic [MARK_W-1:0]   MARK_MAX = MARK_W'(MARKER_COUNT);
    localparam logic [ADDR_W-1:0]   ADDR_END = ADDR_W'(STORE_DEPTH - 1);

    // Configuration registers
    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [POWER_W-1:0] r_threshold;

    // Frame position and peak tracking
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [POWER_W-1:0] r_peak;
    logic [SUMX_W-1:0]  r_sum_x;
    logic [SUMY_W-1:0]  r_sum_y;
    logic [CNT_W-1:0]   r_count;
    logic [MARK_W-1:0]  r_markers;

    // Write-back stage
    logic               r_b_valid;
    logic               r_b_last;
    logic [ADDR_W-1:0]  r_b_addr;
    logic [PIX_W-1:0]   r_b_diff;
    logic [COL_W-1:0]   r_b_col;
    logic [ROW_W-1:0]   r_b_row;

    // Forward of the previous cycle's write
    logic               r_fwd_valid;
    logic [ADDR_W-1:0]  r_fwd_addr;
    logic [POWER_W-1:0] r_fwd_data;

    // Store clear sweep
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Frame-end result
    logic               r_eval;
    logic [POWER_W-1:0] r_res_peak;
    logic               r_res_found;
    logic [MARK_W-1:0]  r_res_markers;
    logic               r_res_all;

    // Output register
    logic               r_out_valid;
    logic [POWER_W-1:0] r_out_peak;
    logic [CX_W-1:0]    r_out_cx;
    logic [CY_W-1:0]    r_out_cy;
    logic               r_out_found;
    logic [MARK_W-1:0]  r_out_markers;
    logic               r_out_all;

    logic               in_acc;
    logic               pix_acc;
    logic               act_acc;
    logic               out_acc;
    logic [FW_W-1:0]    w_cl;
    logic [FH_W-1:0]    h_cl;
    logic [ADDR_W:0]    addr_full;
    logic               last_col;
    logic               last_row;
    logic [PIX_W-1:0]   diff;
    logic [POWER_W-1:0] mem_rdata;
    logic [POWER_W-1:0] old_val;
    logic [POWER_W:0]   add_full;
    logic [POWER_W-1:0] new_val;
    logic [POWER_W-1:0] n_peak;
    logic [SUMX_W-1:0]  n_sum_x;
    logic [SUMY_W-1:0]  n_sum_y;
    logic [CNT_W-1:0]   n_count;
    logic               found;
    logic               frame_end;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [POWER_W-1:0] mem_wdata;
    logic               div_take;
    t_div_ctl           div_ctl;
    logic [CX_W-1:0]    div_qx;
    logic [CY_W-1:0]    div_qy;

    // Handshakes
    assign o_in_stall = r_clearing || div_ctl.busy || div_ctl.done || (r_b_valid && r_b_last);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign act_acc    = in_acc && (i_action == ACT_CLEAR);
    assign pix_acc    = in_acc && (i_action == ACT_PIXEL) && (r_markers < MARK_MAX);
    assign out_acc    = r_out_valid && !i_out_stall;
    assign frame_end  = r_b_valid && r_b_last;

    // Clamp frame size, form the store address, the row/frame ends and the pixel difference
    always_comb begin
        if (r_frame_width == '0) begin
            w_cl = FW_W'(1);
        end else if (r_frame_width > W_MAX) begin
            w_cl = W_MAX;
        end else begin
            w_cl = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_cl = FH_W'(1);
        end else if (r_frame_height > H_MAX) begin
            h_cl = H_MAX;
        end else begin
            h_cl = r_frame_height;
        end
        addr_full = (ADDR_W+1)'((ADDR_W+1)'(r_row) * (ADDR_W+1)'(w_cl))
                  + (ADDR_W+1)'(r_col);
        last_col  = (FW_W'(r_col) + FW_W'(1)) >= w_cl;
        last_row  = (FH_W'(r_row) + FH_W'(1)) >= h_cl;
        diff      = (i_current_pixel > i_previous_pixel)
                  ? i_current_pixel - i_previous_pixel
                  : i_previous_pixel - i_current_pixel;
    end

    // Saturating accumulate with forwarding, next peak tracking, marker test
    always_comb begin
        old_val  = (r_fwd_valid && (r_fwd_addr == r_b_addr)) ? r_fwd_data : mem_rdata;
        add_full = {1'b0, old_val} + (POWER_W+1)'(r_b_diff);
        new_val  = add_full[POWER_W] ? POWER_SAT : add_full[POWER_W-1:0];
        n_peak   = r_peak;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_count  = r_count;
        if (r_b_valid) begin
            if (new_val > r_peak) begin
                n_peak  = new_val;
                n_sum_x = SUMX_W'(r_b_col);
                n_sum_y = SUMY_W'(r_b_row);
                n_count = CNT_W'(1);
            end else if (new_val == r_peak) begin
                n_sum_x = r_sum_x + SUMX_W'(r_b_col);
                n_sum_y = r_sum_y + SUMY_W'(r_b_row);
                n_count = r_count + CNT_W'(1);
            end
        end
        found = r_res_peak > r_threshold;
    end

    // Store port: clear sweep or write-back
    always_comb begin
        mem_we    = r_clearing || r_b_valid;
        mem_waddr = r_clearing ? r_clr_addr : r_b_addr;
        mem_wdata = r_clearing ? '0 : new_val;
    end

    mhpl_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (pix_acc),
        .i_raddr (addr_full[ADDR_W-1:0]),
        .o_rdata (mem_rdata)
    );

    mhpl_centroid_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (frame_end),
        .i_sum_x  (n_sum_x),
        .i_sum_y  (n_sum_y),
        .i_count  ((n_count == '0) ? CNT_W'(1) : n_count),
        .i_take   (div_take),
        .o_ctl    (div_ctl),
        .o_quot_x (div_qx),
        .o_quot_y (div_qy)
    );

    assign div_take = div_ctl.done && (!r_out_valid || out_acc);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_threshold    <= POWER_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:     r_frame_width  <= i_cfg_wdata[FW_W-1:0];
                REG_FRAME_HEIGHT:    r_frame_height <= i_cfg_wdata[FH_W-1:0];
                REG_POWER_THRESHOLD: r_threshold    <= i_cfg_wdata[POWER_W-1:0];
                default: ;
            endcase
        end
    end

    // Position, tracking, markers and clear sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_peak      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_count     <= '0;
            r_markers   <= '0;
            r_b_valid   <= 1'b0;
            r_b_last    <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_eval      <= 1'b0;
        end else begin
            r_fwd_valid <= r_b_valid;
            r_b_valid   <= pix_acc;
            r_b_last    <= pix_acc && last_col && last_row;
            r_eval      <= frame_end;

            // Advance the frame position
            if (act_acc) begin
                r_col <= '0;
                r_row <= '0;
            end else if (pix_acc) begin
                if (!last_col) begin
                    r_col <= r_col + 1'b1;
                end else begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + 1'b1;
                end
            end

            // Update or drop the peak tracking
            if (act_acc || frame_end) begin
                r_peak  <= '0;
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_count <= '0;
            end else if (r_b_valid) begin
                r_peak  <= n_peak;
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_count <= n_count;
            end

            // Count markers
            if (act_acc) begin
                r_markers <= '0;
            end else if (r_eval && found) begin
                r_markers <= r_markers + 1'b1;
            end

            // Sweep the store
            if (act_acc || (r_eval && found)) begin
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_END) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // Stage payload, forward data and frame-end result fields
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_b_addr <= addr_full[ADDR_W-1:0];
            r_b_diff <= diff;
            r_b_col  <= r_col;
            r_b_row  <= r_row;
        end
        r_fwd_addr <= r_b_addr;
        r_fwd_data <= new_val;
        if (frame_end) begin
            r_res_peak <= n_peak;
        end
        if (r_eval) begin
            r_res_found   <= found;
            r_res_markers <= r_markers + MARK_W'(found);
            r_res_all     <= (r_markers + MARK_W'(found)) >= MARK_MAX;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_take) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_take) begin
            r_out_peak    <= r_res_peak;
            r_out_cx      <= div_qx;
            r_out_cy      <= div_qy;
            r_out_found   <= r_res_found;
            r_out_markers <= r_res_markers;
            r_out_all     <= r_res_all;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_peak_power    = r_out_peak;
    assign o_centroid_x    = r_out_cx;
    assign o_centroid_y    = r_out_cy;
    assign o_marker_found  = r_out_found;
    assign o_marker_number = r_out_markers;
    assign o_all_found     = r_out_all;

    // Checks
    a_no_sweep_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clearing && r_b_valid))
        else $error("store sweep overlaps a write-back");

    a_frame_end_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> div_ctl.busy && !r_b_valid)
        else $error("frame end did not start the divider alone");

    a_markers_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_markers <= MARK_MAX)
        else $error("marker count beyond limit");

    a_out_from_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || out_acc) && !div_ctl.done |=> !r_out_valid)
        else $error("result word without a finished division");

endmodule

### test/hot_point_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the locator, predicts the frame-end words and
// compares every accepted output word with the oldest prediction.
module hot_point_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mhpl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mhpl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_action,
    input  logic [mhpl_pkg::PIX_W-1:0]      i_current_pixel,
    input  logic [mhpl_pkg::PIX_W-1:0]      i_previous_pixel,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [mhpl_pkg::POWER_W-1:0]    i_peak_power,
    input  logic [mhpl_pkg::CX_W-1:0]       i_centroid_x,
    input  logic [mhpl_pkg::CY_W-1:0]       i_centroid_y,
    input  logic                            i_marker_found,
    input  logic [mhpl_pkg::MARK_W-1:0]     i_marker_number,
    input  logic                            i_all_found,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_words_checked,
    output int                              o_markers
);
    import mhpl_pkg::*;

    typedef struct packed {
        logic [POWER_W-1:0] peak;
        logic [CX_W-1:0]    cx;
        logic [CY_W-1:0]    cy;
        logic               found;
        logic [MARK_W-1:0]  number;
        logic               all_found;
    } t_hot_point;

    // Shadow registers
    logic [FW_W-1:0]    frame_width;
    logic [FH_W-1:0]    frame_height;
    logic [POWER_W-1:0] power_threshold;

    // Shadow state of the locator; store entries never written read as zero
    logic [POWER_W-1:0] power_store [int unsigned];
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [POWER_W-1:0] frame_peak;
    longint unsigned    peak_col_sum;
    longint unsigned    peak_row_sum;
    longint unsigned    peak_hits;
    int unsigned        markers_found;

    t_hot_point pending_hot_points [$];
    t_hot_point want;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_words_checked = 0;
        o_markers       = 0;
    end

    // Restart frame tracking at the top-left pixel
    task restart_frame();
        col_pos      = 0;
        row_pos      = 0;
        frame_peak   = '0;
        peak_col_sum = 0;
        peak_row_sum = 0;
        peak_hits    = 0;
    endtask

    // Advance the shadow locator by one input word
    task advance_locator(input logic act, input logic [PIX_W-1:0] cur,
                         input logic [PIX_W-1:0] prev);
        int unsigned     cols;
        int unsigned     rows;
        int unsigned     addr;
        logic [PIX_W-1:0] diff;
        logic [POWER_W:0] total;
        logic [POWER_W-1:0] acc;
        longint unsigned divisor;
        longint unsigned quot_x;
        longint unsigned quot_y;
        t_hot_point      hp;
        if (act == ACT_CLEAR) begin
            markers_found = 0;
            power_store.delete();
            restart_frame();
        end else if (markers_found < MARKER_COUNT) begin
            cols = (frame_width == 0) ? 1 : (frame_width > MAX_WIDTH) ? MAX_WIDTH : frame_width;
            rows = (frame_height == 0) ? 1 :
                   (frame_height > MAX_HEIGHT) ? MAX_HEIGHT : frame_height;
            addr = (row_pos * cols + col_pos) % STORE_DEPTH;
            diff = (cur > prev) ? cur - prev : prev - cur;
            total = (power_store.exists(addr) ? power_store[addr] : '0) + diff;
            acc = (total > POWER_SAT) ? POWER_SAT : total[POWER_W-1:0];
            power_store[addr] = acc;

            // Track the peak and the positions that hold it
            if (acc > frame_peak) begin
                frame_peak   = acc;
                peak_col_sum = col_pos;
                peak_row_sum = row_pos;
                peak_hits    = 1;
            end else if (acc == frame_peak) begin
                peak_col_sum += col_pos;
                peak_row_sum += row_pos;
                peak_hits++;
            end

            if (col_pos + 1 < cols) begin
                col_pos++;
            end else begin
                col_pos = 0;
                if (row_pos + 1 < rows) begin
                    row_pos++;
                end else begin
                    // Frame end: centroid from the sums before any clearing
                    divisor = (peak_hits != 0) ? peak_hits : 1;
                    quot_x = (peak_col_sum * 16) / divisor;
                    quot_y = (peak_row_sum * 16) / divisor;
                    hp.peak  = frame_peak;
                    hp.cx    = quot_x[CX_W-1:0];
                    hp.cy    = quot_y[CY_W-1:0];
                    hp.found = (frame_peak > power_threshold);
                    if (hp.found) begin
                        power_store.delete();
                        markers_found++;
                        o_markers++;
                    end
                    hp.number    = markers_found[MARK_W-1:0];
                    hp.all_found = (markers_found >= MARKER_COUNT);
                    pending_hot_points.push_back(hp);
                    restart_frame();
                end
            end
        end
    endtask

    task automatic check_field(input string name, input longint unsigned exp_val,
                               input longint unsigned act_val);
        if (exp_val != act_val) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_width     = FRAME_WIDTH_RST;
            frame_height    = FRAME_HEIGHT_RST;
            power_threshold = POWER_THRESHOLD_RST;
            power_store.delete();
            restart_frame();
            markers_found = 0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:     frame_width = i_cfg_wdata[FW_W-1:0];
                    REG_FRAME_HEIGHT:    frame_height = i_cfg_wdata[FH_W-1:0];
                    REG_POWER_THRESHOLD: power_threshold = i_cfg_wdata[POWER_W-1:0];
                    default: ;
                endcase
            end

            // Accepted input word
            if (i_in_valid && !i_in_stall) begin
                advance_locator(i_action, i_current_pixel, i_previous_pixel);
            end

            // Accepted output word
            if (i_out_valid && !i_out_stall) begin
                if (pending_hot_points.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: output word with nothing pending, %s %0d",
                             $time, "expected none, actual peak", i_peak_power);
                end else begin
                    want = pending_hot_points.pop_front();
                    o_words_checked++;
                    check_field("peak_power", want.peak, i_peak_power);
                    check_field("centroid_x", want.cx, i_centroid_x);
                    check_field("centroid_y", want.cy, i_centroid_y);
                    check_field("marker_found", want.found, i_marker_found);
                    check_field("marker_number", want.number, i_marker_number);
                    check_field("all_found", want.all_found, i_all_found);
                end
            end
        end
        o_pending = pending_hot_points.size();
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mhpl_pkg::*;

    localparam int IDLE_LIMIT   = 2_000_000;
    localparam int RANDOM_WORDS = 1600;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 3000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  i_action = ACT_PIXEL;
    logic [PIX_W-1:0]      i_current_pixel = '0;
    logic [PIX_W-1:0]      i_previous_pixel = '0;
    logic                  i_out_stall = 1'b0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [POWER_W-1:0]    o_peak_power;
    logic [CX_W-1:0]       o_centroid_x;
    logic [CY_W-1:0]       o_centroid_y;
    logic                  o_marker_found;
    logic [MARK_W-1:0]     o_marker_number;
    logic                  o_all_found;

    int fail_count;
    int pending;
    int words_checked;
    int markers;
    int sent_words = 0;
    bit burst = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int stall_left = 0;
    int free_left = 0;

    always #6 i_clk = ~i_clk;

    motion_hot_point_locator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_current_pixel  (i_current_pixel),
        .i_previous_pixel (i_previous_pixel),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_peak_power     (o_peak_power),
        .o_centroid_x     (o_centroid_x),
        .o_centroid_y     (o_centroid_y),
        .o_marker_found   (o_marker_found),
        .o_marker_number  (o_marker_number),
        .o_all_found      (o_all_found)
    );

    hot_point_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_current_pixel  (i_current_pixel),
        .i_previous_pixel (i_previous_pixel),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_peak_power     (o_peak_power),
        .i_centroid_x     (o_centroid_x),
        .i_centroid_y     (o_centroid_y),
        .i_marker_found   (o_marker_found),
        .i_marker_number  (o_marker_number),
        .i_all_found      (o_all_found),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_words_checked  (words_checked),
        .o_markers        (markers)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(12, 80);
    endfunction

    // Pixel pairs: equal pairs for ties, extremes, and plain random values
    task automatic pick_pair(output logic [PIX_W-1:0] cur, output logic [PIX_W-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            cur  = PIX_W'($urandom());
            prev = cur;
        end else if (r < 50) begin
            cur  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            prev = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            cur  = PIX_W'($urandom());
            prev = PIX_W'($urandom());
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one word and hold it until taken; returns at a falling edge
    task automatic offer_word(input logic act, input logic [PIX_W-1:0] cur,
                              input logic [PIX_W-1:0] prev);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_current_pixel  <= cur;
        i_previous_pixel <= prev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_words++;
        @(negedge i_clk);
    endtask

    // Wait for every pending word, then let the pipeline drain
    task automatic settle();
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Receiver: random stalls, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) begin
                i_out_stall <= 1'b0;
                free_left = pick_gap();
            end
        end else if (free_left > 0) begin
            free_left--;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
            end else begin
                free_left = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(50, 200);
            end
        end
    end

    // Watchdog: end the run if no word moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle = 0;
            else idle++;
        end
        $display("Watchdog: %0d cycles without a word moving", IDLE_LIMIT);
        $display("[motion_hot_point_locator] ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [PIX_W-1:0]      cur;
        logic [PIX_W-1:0]      prev;
        logic [CFG_DATA_W-1:0] data;
        int                    cols;
        int                    rows;
        int                    r;
        int                    n;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Flat frame with zero threshold: peak of zero is not a marker
        settle();
        write_register(REG_FRAME_WIDTH, 24'd3);
        write_register(REG_FRAME_HEIGHT, 24'd1);
        write_register(REG_POWER_THRESHOLD, 24'd0);
        write_register(REG_SPARE, 24'hA5A5A5);
        offer_word(ACT_PIXEL, 8'd7, 8'd7);
        offer_word(ACT_PIXEL, 8'h00, 8'h00);
        offer_word(ACT_PIXEL, 8'hFF, 8'hFF);
        i_in_valid <= 1'b0;

        // 2x2 frame with a tie on the top row, then a clear in mid-frame
        settle();
        write_register(REG_POWER_THRESHOLD, 24'hFFFFFF);
        write_register(REG_FRAME_WIDTH, 24'd2);
        write_register(REG_FRAME_HEIGHT, 24'd2);
        offer_word(ACT_PIXEL, 8'hFF, 8'h00);
        offer_word(ACT_PIXEL, 8'h00, 8'hFF);
        offer_word(ACT_PIXEL, 8'h00, 8'h00);
        offer_word(ACT_PIXEL, 8'hFF, 8'hFF);
        offer_word(ACT_PIXEL, 8'h55, 8'hAA);
        offer_word(ACT_CLEAR, 8'hAA, 8'h55);
        i_in_valid <= 1'b0;

        // Sizes of zero clamp to one pixel; every pixel finds a marker
        settle();
        write_register(REG_FRAME_WIDTH, 24'd0);
        write_register(REG_FRAME_HEIGHT, 24'hFFFC00);
        write_register(REG_POWER_THRESHOLD, 24'd0);
        offer_word(ACT_PIXEL, 8'd1, 8'd0);
        offer_word(ACT_PIXEL, 8'd0, 8'd1);
        offer_word(ACT_PIXEL, 8'h80, 8'h7F);
        offer_word(ACT_PIXEL, 8'hFF, 8'h00);
        // All markers found: these are dropped
        offer_word(ACT_PIXEL, 8'hFF, 8'h00);
        offer_word(ACT_PIXEL, 8'h12, 8'hED);
        offer_word(ACT_CLEAR, 8'h00, 8'hFF);
        i_in_valid <= 1'b0;

        // Long receiver hold-off while one-pixel frames keep coming
        settle();
        write_register(REG_FRAME_WIDTH, 24'd1);
        write_register(REG_FRAME_HEIGHT, 24'd1);
        write_register(REG_POWER_THRESHOLD, 24'hFFFFFF);
        burst = 1'b1;
        hold_req = 1'b1;
        repeat (30) begin
            pick_pair(cur, prev);
            offer_word(ACT_PIXEL, cur, prev);
        end
        i_in_valid <= 1'b0;

        // Deep rows: one column down to the last row, then widen and narrow mid-row
        settle();
        burst = 1'b0;
        write_register(REG_FRAME_HEIGHT, 24'd1023);
        repeat (MAX_HEIGHT - 1) begin
            pick_pair(cur, prev);
            offer_word(ACT_PIXEL, cur, prev);
        end
        i_in_valid <= 1'b0;
        settle();
        write_register(REG_FRAME_WIDTH, 24'd2047);
        repeat (20) begin
            pick_pair(cur, prev);
            offer_word(ACT_PIXEL, cur, prev);
        end
        i_in_valid <= 1'b0;
        settle();
        write_register(REG_FRAME_WIDTH, 24'd4);
        pick_pair(cur, prev);
        offer_word(ACT_PIXEL, cur, prev);
        i_in_valid <= 1'b0;

        // Random phases: small frames, size changes that may land mid-frame
        while (sent_words < RANDOM_WORDS) begin
            settle();
            r = $urandom_range(0, 99);
            if (r < 80) begin
                cols = $urandom_range(1, 8);
                rows = $urandom_range(1, 6);
            end else if (r < 87) begin
                cols = 0;
                rows = $urandom_range(1, 4);
            end else if (r < 94) begin
                cols = $urandom_range(1, 8);
                rows = 0;
            end else begin
                cols = $urandom_range(9, 40);
                rows = $urandom_range(1, 3);
            end
            data = CFG_DATA_W'(cols);
            if ($urandom_range(0, 9) == 0) begin
                data[CFG_DATA_W-1:FW_W] = (CFG_DATA_W-FW_W)'($urandom());
            end
            write_register(REG_FRAME_WIDTH, data);
            data = CFG_DATA_W'(rows);
            if ($urandom_range(0, 9) == 0) begin
                data[CFG_DATA_W-1:FH_W] = (CFG_DATA_W-FH_W)'($urandom());
            end
            write_register(REG_FRAME_HEIGHT, data);
            if ($urandom_range(0, 1) == 1) begin
                write_register(REG_POWER_THRESHOLD,
                               CFG_DATA_W'($urandom_range(24'h800000, 24'hFFFFFF)));
            end
            burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 48);
            repeat (n) begin
                pick_pair(cur, prev);
                offer_word(ACT_PIXEL, cur, prev);
            end
            i_in_valid <= 1'b0;
        end

        settle();
        $display("Sent %0d input words, checked %0d result words, %0d markers found.",
                 sent_words, words_checked, markers);
        $display("Frames from 1x1 to 1024 columns by 512 rows, %s",
                 "clamped sizes, mid-frame resizes, clears.");
        if (fail_count == 0 && pending == 0) begin
            $display("[motion_hot_point_locator] OK");
        end else begin
            $display("[motion_hot_point_locator] ERROR");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/mhpl_pkg.sv
hw/rtl/mhpl_store.sv
hw/rtl/mhpl_centroid_div.sv
hw/rtl/motion_hot_point_locator.sv
test/hot_point_checker.sv
test/testbench.sv
